// ===== hdl/ssfg_pkg.sv =====
package ssfg_pkg;

	localparam int DATA_BITS   = 32;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
	localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);
	localparam int NUM_GAPS    = 3;
	localparam int GAP_BITS    = 3;
	localparam int SEL_BITS    = 2;

	localparam logic [SEL_BITS-1:0] LAST_GAP = SEL_BITS'(NUM_GAPS - 1);

	typedef logic [DATA_BITS-1:0] data_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [GAP_BITS-1:0]  gap_t;

	// write port of the element store
	typedef struct packed {
		logic  en;
		addr_t addr;
		data_t data;
	} mem_wr_t;

	// tags that follow a store read on its way to the output register
	typedef struct packed {
		logic vld;
		logic last;
		logic ovf;
	} emit_t;

	// gap sequence 5, 3, 1
	function automatic gap_t gap_of(input logic [SEL_BITS-1:0] sel);
		gap_t g;
		case (sel)
			2'd0:    g = 3'd5;
			2'd1:    g = 3'd3;
			default: g = 3'd1;
		endcase
		return g;
	endfunction

endpackage

// ===== hdl/ssfg_store.sv =====
module ssfg_store (
	input  logic             clk,
	input  ssfg_pkg::mem_wr_t wr,
	input  ssfg_pkg::addr_t  raddr,
	output ssfg_pkg::data_t  rdata
);

	ssfg_pkg::data_t mem [ssfg_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/ssfg_seq.sv =====
module ssfg_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ssfg_pkg::data_t   in_value,
	input  logic              in_last,
	input  logic              out_busy,
	input  ssfg_pkg::data_t   rdata,
	output ssfg_pkg::mem_wr_t wr,
	output ssfg_pkg::addr_t   raddr,
	output ssfg_pkg::emit_t   emit_s1
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_KEY,
		ST_CAPT,
		ST_CMP,
		ST_PUT,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	ssfg_pkg::cnt_t               count_q;
	logic                         ovf_q;
	logic [ssfg_pkg::SEL_BITS-1:0] gs_q;
	ssfg_pkg::gap_t               off_q;
	ssfg_pkg::cnt_t               pos_q;
	ssfg_pkg::cnt_t               ins_q;
	ssfg_pkg::cnt_t               k_q;
	ssfg_pkg::data_t              key_q;

	ssfg_pkg::gap_t gap;
	ssfg_pkg::cnt_t gap_w;
	ssfg_pkg::cnt_t ins_dn;
	logic           greater;
	logic           store_room;
	logic           emit_go;

	always_comb begin
		gap        = ssfg_pkg::gap_of(gs_q);
		gap_w      = ssfg_pkg::CNT_BITS'(gap);
		ins_dn     = ins_q - gap_w;
		greater    = $signed(rdata) > $signed(key_q);
		store_room = count_q < ssfg_pkg::CNT_BITS'(ssfg_pkg::STORE_DEPTH);
		emit_go    = (state_q == ST_EMIT) && !emit_s1.vld && !out_busy;
		in_ready   = (state_q == ST_LOAD);

		wr.en   = 1'b0;
		wr.addr = count_q[ssfg_pkg::ADDR_BITS-1:0];
		wr.data = in_value;
		raddr   = pos_q[ssfg_pkg::ADDR_BITS-1:0];

		case (state_q)
			ST_LOAD: begin
				wr.en = in_valid && store_room;
			end
			ST_KEY: begin
				raddr = pos_q[ssfg_pkg::ADDR_BITS-1:0];
			end
			ST_CAPT: begin
				raddr = ins_dn[ssfg_pkg::ADDR_BITS-1:0];
			end
			ST_CMP: begin
				// shift the larger neighbour up, or drop the key into its slot
				wr.en   = 1'b1;
				wr.addr = ins_q[ssfg_pkg::ADDR_BITS-1:0];
				wr.data = greater ? rdata : key_q;
				raddr   = ssfg_pkg::ADDR_BITS'(ins_dn - gap_w);
			end
			ST_PUT: begin
				wr.en   = 1'b1;
				wr.addr = ins_q[ssfg_pkg::ADDR_BITS-1:0];
				wr.data = key_q;
			end
			ST_EMIT: begin
				raddr = k_q[ssfg_pkg::ADDR_BITS-1:0];
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			gs_q    <= '0;
			off_q   <= '0;
			pos_q   <= '0;
			ins_q   <= '0;
			k_q     <= '0;
			key_q   <= '0;
			emit_s1 <= '0;
		end else begin
			emit_s1.vld <= emit_go;
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (store_room) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							gs_q    <= '0;
							off_q   <= '0;
							pos_q   <= ssfg_pkg::CNT_BITS'(ssfg_pkg::gap_of('0));
							state_q <= ST_KEY;
						end
					end
				end
				ST_KEY: begin
					ins_q <= pos_q;
					if (pos_q < count_q) begin
						state_q <= ST_CAPT;
					end else if (off_q + 1'b1 < gap) begin
						// next subsequence of this gap
						off_q <= off_q + 1'b1;
						pos_q <= ssfg_pkg::CNT_BITS'(off_q + 1'b1) + gap_w;
					end else if (gs_q != ssfg_pkg::LAST_GAP) begin
						gs_q  <= gs_q + 1'b1;
						off_q <= '0;
						pos_q <= ssfg_pkg::CNT_BITS'(ssfg_pkg::gap_of(gs_q + 1'b1));
					end else begin
						gs_q    <= '0;
						off_q   <= '0;
						pos_q   <= '0;
						k_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_CAPT: begin
					key_q   <= rdata;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (greater) begin
						ins_q <= ins_dn;
						if (ins_dn >= gap_w) begin
							state_q <= ST_CMP;
						end else begin
							state_q <= ST_PUT;
						end
					end else begin
						pos_q   <= pos_q + gap_w;
						state_q <= ST_KEY;
					end
				end
				ST_PUT: begin
					pos_q   <= pos_q + gap_w;
					state_q <= ST_KEY;
				end
				ST_EMIT: begin
					if (emit_go) begin
						emit_s1.last <= (k_q + 1'b1 == count_q);
						emit_s1.ovf  <= ovf_q;
						k_q          <= k_q + 1'b1;
						if (k_q + 1'b1 == count_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== hdl/shell_sort_fixed_gaps_core.sv =====
// Batch sorter: Shell sort over the fixed gaps 5, 3, 1.
// Slave channel: one signed value per item in s_tdata; the item with s_tlast
// set closes the batch and starts the sort. Up to 64 values are kept; items
// past that are dropped and the whole batch is then flagged in m_tuser.
// Master channel: the batch in ascending order, m_tlast on the final item.
// Loading takes one item per cycle. Sorting runs out of a single-port-write,
// single-port-read store with a registered read port: each gapped insertion
// step fetches the key, compares it with its gapped neighbours and shifts the
// larger ones up, then places the key, and the sequencer then moves on to the
// next subsequence or gap. During emission a store read is issued only once
// the previous one has been captured and the output register is free.
// s_tready is low from the last item of a batch until its last result has
// been read out of the store; a stalled receiver holds the output register
// and pauses the read-out. Reset clears the control state and empties the
// batch; store contents are not cleared.
module shell_sort_fixed_gaps_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [31:0]             s_tdata,   // [31:0] value
	input  logic                    s_tlast,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [31:0]             m_tdata,   // [31:0] sorted_value
	output logic                    m_tlast,
	output logic                    m_tuser    // [0] overflow
);

	ssfg_pkg::mem_wr_t wr;
	ssfg_pkg::addr_t   raddr;
	ssfg_pkg::data_t   rdata;
	ssfg_pkg::emit_t   emit_s1;
	logic              out_busy;

	// output register stays full while the receiver stalls
	assign out_busy = m_tvalid && !m_tready;

	ssfg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata),
		.in_last  (s_tlast),
		.out_busy (out_busy),
		.rdata    (rdata),
		.wr       (wr),
		.raddr    (raddr),
		.emit_s1  (emit_s1)
	);

	ssfg_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	// capture the store read that the sequencer tagged for output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit_s1.vld) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s1.vld) begin
			m_tdata <= rdata;
			m_tlast <= emit_s1.last;
			m_tuser <= emit_s1.ovf;
		end
	end

endmodule
